@@ rtl/spfla_pkg.sv @@
// Shared types and constants for the slot pool allocator.
// Sizes, operation and status codes, and the memory port bundles.
// No dependencies.
package spfla_pkg;

  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS + 1);
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int IN_DW  = ((SLOT_W + 7) / 8) * 8;
  localparam int OUT_DW = ((3 * SLOT_W + 7) / 8) * 8;

  localparam logic [SLOT_W-1:0] SLOT_NONE = SLOT_W'(SLOTS);

  typedef enum logic [1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_BAD   = 2'd2
  } status_t;

  // Write port of a link memory
  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [SLOT_W-1:0] wdata;
  } link_wr_t;

  // Write port of the in-use flag memory
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wdata;
  } flag_wr_t;

  // Read requests, issued when an item is accepted
  typedef struct packed {
    logic             re;
    logic [IDX_W-1:0] free_raddr;
    logic [IDX_W-1:0] slot_raddr;
  } rd_req_t;

  // Registered read data of all four memories
  typedef struct packed {
    logic [SLOT_W-1:0] free_link;
    logic [SLOT_W-1:0] used_next;
    logic [SLOT_W-1:0] used_prev;
    logic              in_use;
  } rd_data_t;

endpackage

@@ rtl/spfla_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port.
// Read data is registered and held while no read is issued. No dependencies.
module spfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/spfla_core.sv @@
// Allocator control: clearing pass, list update logic, head/tail registers
// and the output register. Depends on spfla_pkg; drives the link memories.
module spfla_core
  import spfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,
  input  logic [1:0]        in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,
  output logic [1:0]        out_tuser,
  output rd_req_t           rd_req,
  input  rd_data_t          rd_data,
  output link_wr_t          free_wr,
  output link_wr_t          next_wr,
  output link_wr_t          prev_wr,
  output flag_wr_t          use_wr
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  action_t           act_r;
  logic [SLOT_W-1:0] slot_r;
  logic [SLOT_W-1:0] free_head_r, free_head_nxt;
  logic [SLOT_W-1:0] used_head_r, used_head_nxt;
  logic [SLOT_W-1:0] used_tail_r, used_tail_nxt;
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, status_nxt;
  logic [SLOT_W-1:0] out_res_r, res_nxt;
  logic [SLOT_W-1:0] out_first_r, out_last_r;

  logic              accept;
  logic              slot_ok, busy, fh_ok, tail_ok, p_ok, n_ok;
  logic [SLOT_W-1:0] p_slot, n_slot;
  logic [SLOT_W-1:0] in_slot;

  // Accept one item at a time, only when the output slot will be free
  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;
  assign in_slot   = in_tdata[SLOT_W-1:0];

  // Issue reads for the accepted item
  assign rd_req.re         = accept;
  assign rd_req.free_raddr = free_head_r[IDX_W-1:0];
  assign rd_req.slot_raddr = in_slot[IDX_W-1:0];

  // Decode neighbors of the addressed slot; the tail's successor is none
  assign slot_ok = slot_r < SLOT_NONE;
  assign busy    = slot_ok && rd_data.in_use;
  assign p_slot  = rd_data.used_prev;
  assign n_slot  = (slot_r == used_tail_r) ? SLOT_NONE : rd_data.used_next;
  assign p_ok    = p_slot < SLOT_NONE;
  assign n_ok    = n_slot < SLOT_NONE;
  assign fh_ok   = free_head_r < SLOT_NONE;
  assign tail_ok = used_tail_r < SLOT_NONE;

  // Sequence, list update and memory writes
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    free_head_nxt = free_head_r;
    used_head_nxt = used_head_r;
    used_tail_nxt = used_tail_r;
    status_nxt    = ST_BAD;
    res_nxt       = SLOT_NONE;
    free_wr       = '0;
    next_wr       = '0;
    prev_wr       = '0;
    use_wr        = '0;

    case (state_r)
      S_CLEAR: begin
        // Rebuild the free chain and clear the in-use flags, one row a cycle
        free_wr.we    = 1'b1;
        free_wr.waddr = clr_cnt_r;
        free_wr.wdata = SLOT_W'(clr_cnt_r) + SLOT_W'(1);
        use_wr.we     = 1'b1;
        use_wr.waddr  = clr_cnt_r;
        use_wr.wdata  = 1'b0;
        clr_cnt_nxt   = clr_cnt_r + IDX_W'(1);
        if (clr_cnt_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        case (act_r)
          ACT_ALLOC: begin
            if (fh_ok) begin
              // Pop the free head and append it at the in-use tail
              status_nxt    = ST_OK;
              res_nxt       = free_head_r;
              free_head_nxt = rd_data.free_link;
              next_wr.we    = tail_ok;
              next_wr.waddr = used_tail_r[IDX_W-1:0];
              next_wr.wdata = free_head_r;
              prev_wr.we    = 1'b1;
              prev_wr.waddr = free_head_r[IDX_W-1:0];
              prev_wr.wdata = used_tail_r;
              use_wr.we     = 1'b1;
              use_wr.waddr  = free_head_r[IDX_W-1:0];
              use_wr.wdata  = 1'b1;
              if (!tail_ok) begin
                used_head_nxt = free_head_r;
              end
              used_tail_nxt = free_head_r;
            end else begin
              status_nxt = ST_EMPTY;
            end
          end
          ACT_FREE: begin
            if (busy) begin
              // Unlink from the in-use list and push onto the free head
              status_nxt    = ST_OK;
              next_wr.we    = p_ok;
              next_wr.waddr = p_slot[IDX_W-1:0];
              next_wr.wdata = n_slot;
              prev_wr.we    = n_ok;
              prev_wr.waddr = n_slot[IDX_W-1:0];
              prev_wr.wdata = p_slot;
              if (!p_ok) begin
                used_head_nxt = n_slot;
              end
              if (!n_ok) begin
                used_tail_nxt = p_slot;
              end
              free_wr.we    = 1'b1;
              free_wr.waddr = slot_r[IDX_W-1:0];
              free_wr.wdata = free_head_r;
              use_wr.we     = 1'b1;
              use_wr.waddr  = slot_r[IDX_W-1:0];
              use_wr.wdata  = 1'b0;
              free_head_nxt = slot_r;
            end
          end
          ACT_QUERY: begin
            if (slot_r == SLOT_NONE) begin
              status_nxt = ST_OK;
              res_nxt    = used_head_r;
            end else if (busy) begin
              status_nxt = ST_OK;
              res_nxt    = n_slot;
            end
          end
          default: begin
            status_nxt = ST_BAD;
          end
        endcase
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Load the output register on execution, drop it once transferred
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == S_EXEC) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      free_head_r <= '0;
      used_head_r <= SLOT_NONE;
      used_tail_r <= SLOT_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      free_head_r <= free_head_nxt;
      used_head_r <= used_head_nxt;
      used_tail_r <= used_tail_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      act_r  <= action_t'(in_tuser);
      slot_r <= in_slot;
    end
    if (state_r == S_EXEC) begin
      out_status_r <= status_nxt;
      out_res_r    <= res_nxt;
      out_first_r  <= used_head_nxt;
      out_last_r   <= used_tail_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = OUT_DW'({out_last_r, out_first_r, out_res_r});

endmodule

@@ rtl/slot_pool_free_list_allocator_unit.sv @@
// Slot pool allocator: free list plus doubly linked in-use list in link RAMs.
// An accepted item reads the link RAMs, is executed in the S_EXEC state, and its
// result is then registered at the output. No new item is accepted before the
// read-then-write-back pass through the link RAMs is done and the output is free.
// Reset: synchronous, active low; then a clearing pass over all 64 slots
// rebuilds the free chain and in-use flags, during which no item is accepted.
module slot_pool_free_list_allocator_unit
  import spfla_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // [6:0] slot, zero padded
  input  logic [1:0]        in_tuser,   // [1:0] action
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // [6:0] result_slot, [13:7] first_used,
                                        // [20:14] last_used, zero padded
  output logic [1:0]        out_tuser   // [1:0] status
);

  rd_req_t  rd_req;
  rd_data_t rd_data;
  link_wr_t free_wr, next_wr, prev_wr;
  flag_wr_t use_wr;

  // List control
  spfla_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .rd_req     (rd_req),
    .rd_data    (rd_data),
    .free_wr    (free_wr),
    .next_wr    (next_wr),
    .prev_wr    (prev_wr),
    .use_wr     (use_wr)
  );

  // Free chain links
  spfla_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_free_link (
    .clk   (clk),
    .we    (free_wr.we),
    .waddr (free_wr.waddr),
    .wdata (free_wr.wdata),
    .re    (rd_req.re),
    .raddr (rd_req.free_raddr),
    .rdata (rd_data.free_link)
  );

  // In-use successor links
  spfla_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_used_next (
    .clk   (clk),
    .we    (next_wr.we),
    .waddr (next_wr.waddr),
    .wdata (next_wr.wdata),
    .re    (rd_req.re),
    .raddr (rd_req.slot_raddr),
    .rdata (rd_data.used_next)
  );

  // In-use predecessor links
  spfla_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_used_prev (
    .clk   (clk),
    .we    (prev_wr.we),
    .waddr (prev_wr.waddr),
    .wdata (prev_wr.wdata),
    .re    (rd_req.re),
    .raddr (rd_req.slot_raddr),
    .rdata (rd_data.used_prev)
  );

  // In-use flags
  spfla_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_in_use (
    .clk   (clk),
    .we    (use_wr.we),
    .waddr (use_wr.waddr),
    .wdata (use_wr.wdata),
    .re    (rd_req.re),
    .raddr (rd_req.slot_raddr),
    .rdata (rd_data.in_use)
  );

endmodule
